// ----- rtl/core/mmlp_pkg.sv -----
// Shared constants, types and decode functions for the move message line parser.
package mmlp_pkg;

	localparam int unsigned MAX_PLY_DIGITS_DEF     = 7;
	localparam int unsigned MAX_NOTATION_CHARS_DEF = 8;

	localparam int unsigned CFG_IW = 2;
	localparam int unsigned CFG_DW = 4;

	localparam logic [CFG_IW-1:0] CFG_PLY_CAP  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_MOVE_CAP = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_NOTE_CAP = 2'd2;

	localparam logic [3:0] PLY_CAP_RST  = 4'd8;
	localparam logic [2:0] MOVE_CAP_RST = 3'd6;
	localparam logic [3:0] NOTE_CAP_RST = 4'd9;

	localparam logic [3:0] MOVE_MAX_CHARS = 4'd5;
	localparam logic [2:0] MOVE_MIN_CHARS = 3'd4;
	localparam logic [2:0] PREFIX_LEN     = 3'd5;

	localparam logic [2:0] PH_PREFIX = 3'd0;
	localparam logic [2:0] PH_DIGITS = 3'd1;
	localparam logic [2:0] PH_MOVE   = 3'd2;
	localparam logic [2:0] PH_NOTE   = 3'd3;
	localparam logic [2:0] PH_TAIL   = 3'd4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_8     = 8'h38;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_Q     = 8'h71;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_UM    = 8'h4D;
	localparam logic [7:0] CH_UO    = 8'h4F;
	localparam logic [7:0] CH_UV    = 8'h56;
	localparam logic [7:0] CH_UE    = 8'h45;

	localparam logic [2:0] PROMO_NONE = 3'd0;
	localparam logic [2:0] PROMO_Q    = 3'd1;
	localparam logic [2:0] PROMO_R    = 3'd2;
	localparam logic [2:0] PROMO_B    = 3'd3;
	localparam logic [2:0] PROMO_N    = 3'd4;

	typedef struct packed {
		logic       ok;
		logic [2:0] code;
	} move_code_t;

	// Usable characters for a buffer of the given size, clamped to a hard maximum.
	function automatic logic [3:0] cap_limit(input logic [3:0] cap, input logic [3:0] most);
		logic [3:0] lim;
		lim = (cap == 4'd0) ? 4'd0 : cap - 4'd1;
		return (lim > most) ? most : lim;
	endfunction

	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = CH_UM;
			3'd1:    c = CH_UO;
			3'd2:    c = CH_UV;
			3'd3:    c = CH_UE;
			3'd4:    c = CH_SPACE;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic move_code_t move_code(input logic [2:0] pos, input logic [7:0] c);
		move_code_t r;
		r = '{ok: 1'b0, code: 3'd0};
		case (pos)
			3'd0, 3'd2: begin
				if (c inside {[CH_A:CH_H]}) begin
					r.ok   = 1'b1;
					r.code = 3'(c - CH_A);
				end
			end
			3'd1, 3'd3: begin
				if (c inside {[CH_1:CH_8]}) begin
					r.ok   = 1'b1;
					r.code = 3'(c - CH_1);
				end
			end
			default: begin
				case (c)
					CH_Q:    r = '{ok: 1'b1, code: PROMO_Q};
					CH_R:    r = '{ok: 1'b1, code: PROMO_R};
					CH_B:    r = '{ok: 1'b1, code: PROMO_B};
					CH_N:    r = '{ok: 1'b1, code: PROMO_N};
					default: r = '{ok: 1'b0, code: PROMO_NONE};
				endcase
			end
		endcase
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

endpackage

// ----- rtl/core/move_message_line_parser_unit.sv -----
// Top level of the move message line parser: input stage, parse state and result register.
// A line-ending zero word is registered in the input stage, then loaded into the result
//   register, which raises out_valid. Other words only update the parse state.
// Throughput: one word per cycle; a zero word waits in the input stage only while the
//   previous result is still held on the output and not taken.
// Reset: arst_n clears parse state and handshake flags and restores capacities 8, 6, 9.
module move_message_line_parser_unit #(
	parameter int unsigned MAX_PLY_DIGITS     = mmlp_pkg::MAX_PLY_DIGITS_DEF,
	parameter int unsigned MAX_NOTATION_CHARS = mmlp_pkg::MAX_NOTATION_CHARS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [mmlp_pkg::CFG_IW-1:0] cfg_index,
	input  logic [mmlp_pkg::CFG_DW-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  line_char,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        line_ok,
	output logic [23:0]                 ply_value,
	output logic [2:0]                  ply_digit_count,
	output logic [2:0]                  from_file,
	output logic [2:0]                  from_rank,
	output logic [2:0]                  to_file,
	output logic [2:0]                  to_rank,
	output logic [2:0]                  promotion,
	output logic [63:0]                 notation_bytes,
	output logic [3:0]                  notation_length
);
	import mmlp_pkg::*;

	localparam int unsigned PCW = $clog2(MAX_PLY_DIGITS + 1);
	localparam int unsigned NCW = $clog2(MAX_NOTATION_CHARS + 1);
	localparam int unsigned NIW = (MAX_NOTATION_CHARS > 1) ? $clog2(MAX_NOTATION_CHARS) : 1;
	localparam logic [3:0]  PLY_MOST  = 4'(MAX_PLY_DIGITS);
	localparam logic [3:0]  NOTE_MOST = 4'(MAX_NOTATION_CHARS);

	// Capacity registers, read on every word.
	logic [3:0] ply_cap_q;
	logic [2:0] mv_cap_q;
	logic [3:0] note_cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ply_cap_q  <= PLY_CAP_RST;
			mv_cap_q   <= MOVE_CAP_RST;
			note_cap_q <= NOTE_CAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PLY_CAP:  ply_cap_q  <= cfg_data[3:0];
				CFG_MOVE_CAP: mv_cap_q   <= cfg_data[2:0];
				CFG_NOTE_CAP: note_cap_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	logic [3:0] ply_lim, move_lim, note_lim;
	assign ply_lim  = cap_limit(ply_cap_q, PLY_MOST);
	assign move_lim = cap_limit({1'b0, mv_cap_q}, MOVE_MAX_CHARS);
	assign note_lim = cap_limit(note_cap_q, NOTE_MOST);

	// Input stage: one word held until the parse step consumes it.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       out_valid_q;
	logic       advance;
	logic       line_end;

	// A nonzero word only updates state; a zero word also needs the result slot.
	assign line_end = valid_s1 && (char_s1 == CH_NUL);
	assign advance  = valid_s1 && ((char_s1 != CH_NUL) || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= line_char;
		end
	end

	// Parse state of the current line.
	logic [2:0]     phase_q, phase_d;
	logic [2:0]     pcount_q, pcount_d;
	logic           failed_q, failed_d;
	logic [23:0]    acc_q, acc_d;
	logic [PCW-1:0] digits_q, digits_d;
	logic [14:0]    mfields_q, mfields_d;
	logic [2:0]     mlen_q, mlen_d;
	logic [NCW-1:0] ncount_q, ncount_d;
	logic           note_we;
	logic [7:0]     note_q [MAX_NOTATION_CHARS];

	move_code_t  mc;
	logic [23:0] dval;

	assign mc   = move_code(mlen_q, char_s1);
	assign dval = {20'd0, 4'(char_s1 - CH_0)};

	always_comb begin
		phase_d   = phase_q;
		pcount_d  = pcount_q;
		failed_d  = failed_q;
		acc_d     = acc_q;
		digits_d  = digits_q;
		mfields_d = mfields_q;
		mlen_d    = mlen_q;
		ncount_d  = ncount_q;
		note_we   = 1'b0;
		if (advance) begin
			if (char_s1 == CH_NUL) begin
				// Line ends: start the next one from scratch.
				phase_d   = PH_PREFIX;
				pcount_d  = 3'd0;
				failed_d  = 1'b0;
				acc_d     = 24'd0;
				digits_d  = '0;
				mfields_d = 15'd0;
				mlen_d    = 3'd0;
				ncount_d  = '0;
			end else if (!failed_q) begin
				case (phase_q)
					PH_PREFIX: begin
						if (pcount_q < PREFIX_LEN && char_s1 == prefix_char(pcount_q)) begin
							pcount_d = pcount_q + 3'd1;
							if (pcount_q == PREFIX_LEN - 3'd1) begin
								phase_d = PH_DIGITS;
							end
						end else begin
							failed_d = 1'b1;
						end
					end
					PH_DIGITS: begin
						if (is_digit(char_s1) && 4'(digits_q) < ply_lim) begin
							// times ten as two shifts and an add
							acc_d    = (acc_q << 3) + (acc_q << 1) + dval;
							digits_d = digits_q + PCW'(1);
						end else if (char_s1 == CH_SPACE && digits_q != '0) begin
							phase_d = PH_MOVE;
						end else begin
							failed_d = 1'b1;
						end
					end
					PH_MOVE: begin
						if (char_s1 == CH_SPACE) begin
							if (mlen_q < MOVE_MIN_CHARS) begin
								failed_d = 1'b1;
							end else begin
								phase_d = (note_cap_q == 4'd0) ? PH_TAIL : PH_NOTE;
							end
						end else if ({1'b0, mlen_q} >= move_lim || !mc.ok) begin
							failed_d = 1'b1;
						end else begin
							for (int i = 0; i < 5; i++) begin
								if (mlen_q == 3'(i)) begin
									mfields_d[3*i +: 3] = mc.code;
								end
							end
							mlen_d = mlen_q + 3'd1;
						end
					end
					PH_NOTE: begin
						// A space or a full buffer closes the notation; the rest is ignored.
						if (char_s1 == CH_SPACE || 4'(ncount_q) >= note_lim) begin
							phase_d = PH_TAIL;
						end else begin
							note_we  = 1'b1;
							ncount_d = ncount_q + NCW'(1);
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PREFIX;
			pcount_q  <= 3'd0;
			failed_q  <= 1'b0;
			acc_q     <= 24'd0;
			digits_q  <= '0;
			mfields_q <= 15'd0;
			mlen_q    <= 3'd0;
			ncount_q  <= '0;
		end else begin
			phase_q   <= phase_d;
			pcount_q  <= pcount_d;
			failed_q  <= failed_d;
			acc_q     <= acc_d;
			digits_q  <= digits_d;
			mfields_q <= mfields_d;
			mlen_q    <= mlen_d;
			ncount_q  <= ncount_d;
		end
	end

	// Notation bytes: only entries below the count are ever read, so no clearing.
	always_ff @(posedge clk) begin
		if (note_we) begin
			note_q[ncount_q[NIW-1:0]] <= char_s1;
		end
	end

	// Verdict and field assembly for the line being closed.
	logic        ok_now;
	logic        note_show;
	logic [63:0] note_pack;

	assign ok_now = !failed_q && (phase_q == PH_NOTE || phase_q == PH_TAIL ||
		(phase_q == PH_MOVE && mlen_q >= MOVE_MIN_CHARS));

	// Drop a notation that opens with a digit.
	assign note_show = (ncount_q != '0) && !is_digit(note_q[0]);

	for (genvar i = 0; i < 8; i++) begin : g_pack
		if (i < MAX_NOTATION_CHARS) begin : g_used
			assign note_pack[8*i +: 8] = (4'(ncount_q) > 4'(i)) ? note_q[i] : 8'd0;
		end else begin : g_pad
			assign note_pack[8*i +: 8] = 8'd0;
		end
	end

	// Result register: loaded when a zero word leaves the input stage.
	logic        res_ok_q;
	logic [23:0] res_ply_q;
	logic [2:0]  res_digits_q;
	logic [14:0] res_move_q;
	logic [63:0] res_note_q;
	logic [3:0]  res_nlen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && line_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && line_end) begin
			res_ok_q     <= ok_now;
			res_ply_q    <= ok_now ? acc_q : 24'd0;
			res_digits_q <= ok_now ? 3'(digits_q) : 3'd0;
			res_move_q   <= ok_now ? mfields_q : 15'd0;
			res_note_q   <= (ok_now && note_show) ? note_pack : 64'd0;
			res_nlen_q   <= (ok_now && note_show) ? 4'(ncount_q) : 4'd0;
		end
	end

	assign out_valid       = out_valid_q;
	assign line_ok         = res_ok_q;
	assign ply_value       = res_ply_q;
	assign ply_digit_count = res_digits_q;
	assign from_file       = res_move_q[2:0];
	assign from_rank       = res_move_q[5:3];
	assign to_file         = res_move_q[8:6];
	assign to_rank         = res_move_q[11:9];
	assign promotion       = res_move_q[14:12];
	assign notation_bytes  = res_note_q;
	assign notation_length = res_nlen_q;

endmodule

// ----- rtl/core/mmlp_checker.sv -----
// Port-level checks for the move message line parser, bound to the top level.
module mmlp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        line_ok,
	input logic [23:0] ply_value,
	input logic [2:0]  ply_digit_count,
	input logic [2:0]  from_file,
	input logic [2:0]  from_rank,
	input logic [2:0]  to_file,
	input logic [2:0]  to_rank,
	input logic [2:0]  promotion,
	input logic [63:0] notation_bytes,
	input logic [3:0]  notation_length
);
	import mmlp_pkg::*;

	// A held word keeps its verdict, ply value and notation until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line_ok) &&
		$stable(ply_value) && $stable(notation_bytes) && $stable(notation_length))
		else $error("result word changed while stalled");

	// A rejected line carries nothing but the verdict.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_ok |-> ply_value == 24'd0 && ply_digit_count == 3'd0 &&
		from_file == 3'd0 && from_rank == 3'd0 && to_file == 3'd0 && to_rank == 3'd0 &&
		promotion == 3'd0 && notation_bytes == 64'd0 && notation_length == 4'd0)
		else $error("rejected line with nonzero fields");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> promotion <= PROMO_N && notation_length <= 4'd8)
		else $error("promotion or notation length out of range");

	// A notation that opens with a digit must have been dropped.
	a_digit_note: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && notation_length != 4'd0 |->
		!(notation_bytes[7:0] >= CH_0 && notation_bytes[7:0] <= CH_9))
		else $error("notation starting with a digit was reported");

endmodule

bind move_message_line_parser_unit mmlp_checker u_mmlp_checker (.*);

// ----- dv/move_message_line_parser_unit_tb.sv -----
// Self-checking testbench for the move message line parser: directed table, then random lines.
`timescale 1ns / 100ps

module move_message_line_parser_unit_tb;
	import mmlp_pkg::*;

	localparam int RANDOM_WORDS    = 280;
	localparam int RANDOM_LINES    = 12;
	localparam int LINES_PER_PHASE = 4;
	localparam int SETTLE_CYCLES   = 4;
	localparam int STALL_LIMIT     = 2000;

	localparam logic [7:0] PREFIX_CHARS [5] = '{CH_UM, CH_UO, CH_UV, CH_UE, CH_SPACE};
	localparam logic [7:0] PROMO_CHARS  [4] = '{CH_Q, CH_R, CH_B, CH_N};

	typedef struct packed {
		logic        line_ok;
		logic [23:0] ply_value;
		logic [2:0]  ply_digit_count;
		logic [2:0]  from_file;
		logic [2:0]  from_rank;
		logic [2:0]  to_file;
		logic [2:0]  to_rank;
		logic [2:0]  promotion;
		logic [63:0] notation_bytes;
		logic [3:0]  notation_length;
	} move_report_t;

	typedef enum logic {ROW_LINE, ROW_CAPS} row_kind_t;

	typedef struct {
		row_kind_t    kind;
		string        text;
		bit           typed;
		move_report_t rpt;
		logic [3:0]   ply_cap;
		logic [2:0]   mv_cap;
		logic [3:0]   note_cap;
	} dir_row_t;

	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [3:0]  cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  line_char = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        line_ok;
	logic [23:0] ply_value;
	logic [2:0]  ply_digit_count;
	logic [2:0]  from_file;
	logic [2:0]  from_rank;
	logic [2:0]  to_file;
	logic [2:0]  to_rank;
	logic [2:0]  promotion;
	logic [63:0] notation_bytes;
	logic [3:0]  notation_length;

	move_message_line_parser_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.line_char       (line_char),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.line_ok         (line_ok),
		.ply_value       (ply_value),
		.ply_digit_count (ply_digit_count),
		.from_file       (from_file),
		.from_rank       (from_rank),
		.to_file         (to_file),
		.to_rank         (to_rank),
		.promotion       (promotion),
		.notation_bytes  (notation_bytes),
		.notation_length (notation_length)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Parser mirror: capacities and per-line state, updated on every accepted word
	logic [3:0]  cap_ply  = PLY_CAP_RST;
	logic [2:0]  cap_move = MOVE_CAP_RST;
	logic [3:0]  cap_note = NOTE_CAP_RST;
	logic [2:0]  phase    = PH_PREFIX;
	int          prefix_seen;
	bit          failed;
	logic [23:0] ply_acc;
	logic [2:0]  ply_cnt;
	logic [14:0] move_bits;
	logic [2:0]  move_chars;
	logic [63:0] note_buf;
	logic [3:0]  note_cnt;

	move_report_t pending_reports [$];
	dir_row_t     dir_rows [$];
	logic [7:0]   line_bytes [$];

	// A typed row replaces the mirror's report for its line ending
	bit           typed_on;
	move_report_t typed_rpt;

	int       fail_count;
	int       words_sent;
	int       burst_left;
	int       stall_cycles;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left;
	move_report_t got_rpt;

	// Usable characters of a buffer: one slot goes to the terminator, then clamp
	function automatic int room(input int cap, input int most);
		int n;
		n = (cap == 0) ? 0 : cap - 1;
		return (n > most) ? most : n;
	endfunction

	// Field code of a move character at a position, or -1 when it does not fit there
	function automatic int square_code(input int pos, input logic [7:0] c);
		if (pos == 0 || pos == 2)
			return (c >= CH_A && c <= CH_H) ? int'(c - CH_A) : -1;
		if (pos == 1 || pos == 3)
			return (c >= CH_1 && c <= CH_8) ? int'(c - CH_1) : -1;
		case (c)
			CH_Q:    return int'(PROMO_Q);
			CH_R:    return int'(PROMO_R);
			CH_B:    return int'(PROMO_B);
			CH_N:    return int'(PROMO_N);
			default: return -1;
		endcase
	endfunction

	function automatic bit is_num(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	task automatic clear_line();
		phase       = PH_PREFIX;
		prefix_seen = 0;
		failed      = 1'b0;
		ply_acc     = '0;
		ply_cnt     = '0;
		move_bits   = '0;
		move_chars  = '0;
		note_buf    = '0;
		note_cnt    = '0;
	endtask

	// Advance the mirror by one accepted word; a zero word queues the line's report
	task automatic parse_byte(input logic [7:0] c);
		move_report_t r;
		int code;
		if (c == CH_NUL) begin
			r = '0;
			if (!failed && (phase == PH_NOTE || phase == PH_TAIL ||
					(phase == PH_MOVE && move_chars >= MOVE_MIN_CHARS))) begin
				r.line_ok         = 1'b1;
				r.ply_value       = ply_acc;
				r.ply_digit_count = ply_cnt;
				r.from_file       = move_bits[2:0];
				r.from_rank       = move_bits[5:3];
				r.to_file         = move_bits[8:6];
				r.to_rank         = move_bits[11:9];
				r.promotion       = move_bits[14:12];
				// Drop a notation that opens with a digit
				if (note_cnt != 0 && !is_num(note_buf[7:0])) begin
					r.notation_bytes  = note_buf;
					r.notation_length = note_cnt;
				end
			end
			pending_reports.push_back(typed_on ? typed_rpt : r);
			clear_line();
		end else if (!failed) begin
			case (phase)
				PH_PREFIX: begin
					if (prefix_seen < 5 && c == PREFIX_CHARS[prefix_seen]) begin
						prefix_seen++;
						if (prefix_seen == 5)
							phase = PH_DIGITS;
					end else begin
						failed = 1'b1;
					end
				end
				PH_DIGITS: begin
					if (is_num(c) && ply_cnt < room(cap_ply, MAX_PLY_DIGITS_DEF)) begin
						ply_acc = ply_acc * 24'd10 + 24'(c - CH_0);
						ply_cnt++;
					end else if (c == CH_SPACE && ply_cnt > 0) begin
						phase = PH_MOVE;
					end else begin
						failed = 1'b1;
					end
				end
				PH_MOVE: begin
					if (c == CH_SPACE) begin
						if (move_chars < MOVE_MIN_CHARS)
							failed = 1'b1;
						else
							phase = (cap_note == 0) ? PH_TAIL : PH_NOTE;
					end else if (move_chars >= room(cap_move, 5)) begin
						failed = 1'b1;
					end else begin
						code = square_code(move_chars, c);
						if (code < 0) begin
							failed = 1'b1;
						end else begin
							move_bits = move_bits | (15'(code) << (3 * int'(move_chars)));
							move_chars++;
						end
					end
				end
				PH_NOTE: begin
					// A space or a full buffer ends capture; the rest is ignored
					if (c == CH_SPACE || note_cnt >= room(cap_note, MAX_NOTATION_CHARS_DEF)) begin
						phase = PH_TAIL;
					end else begin
						note_buf = note_buf | (64'(c) << (8 * int'(note_cnt[2:0])));
						note_cnt++;
					end
				end
				default: ;
			endcase
		end
	endtask

	// Drive one word in bursts with random gaps; hold valid and payload until taken
	task automatic send_char(input logic [7:0] c);
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid  <= 1'b1;
		line_char <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
		words_sent++;
		parse_byte(c);
	endtask

	// Stop sending and wait until every report has been taken, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three capacities back to back; call only with the block idle
	task automatic program_caps(input logic [3:0] ply, input logic [2:0] mv,
			input logic [3:0] note);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PLY_CAP;
		cfg_data  <= ply;
		@(posedge clk);
		cfg_index <= CFG_MOVE_CAP;
		cfg_data  <= 4'(mv);
		@(posedge clk);
		cfg_index <= CFG_NOTE_CAP;
		cfg_data  <= note;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cap_ply  = ply;
		cap_move = mv;
		cap_note = note;
	endtask

	function automatic dir_row_t line_row(input string text, input bit typed,
			input move_report_t rpt);
		dir_row_t r;
		r.kind  = ROW_LINE;
		r.text  = text;
		r.typed = typed;
		r.rpt   = rpt;
		return r;
	endfunction

	function automatic dir_row_t caps_row(input logic [3:0] ply, input logic [2:0] mv,
			input logic [3:0] note);
		dir_row_t r;
		r.kind     = ROW_CAPS;
		r.text     = "";
		r.typed    = 1'b0;
		r.rpt      = '0;
		r.ply_cap  = ply;
		r.mv_cap   = mv;
		r.note_cap = note;
		return r;
	endfunction

	function automatic move_report_t good_report(input logic [23:0] ply, input logic [2:0] cnt,
			input logic [2:0] ff, input logic [2:0] fr, input logic [2:0] tf,
			input logic [2:0] tr, input logic [2:0] pr);
		move_report_t r;
		r                 = '0;
		r.line_ok         = 1'b1;
		r.ply_value       = ply;
		r.ply_digit_count = cnt;
		r.from_file       = ff;
		r.from_rank       = fr;
		r.to_file         = tf;
		r.to_rank         = tr;
		r.promotion       = pr;
		return r;
	endfunction

	// Build one random line: mostly well-formed with random content, some noise or damage
	task automatic compose_line();
		int kind;
		int n;
		int lim;
		int pos;
		line_bytes.delete();
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			n = $urandom_range(0, 14);
			repeat (n) line_bytes.push_back(8'($urandom_range(1, 255)));
		end else begin
			foreach (PREFIX_CHARS[i])
				line_bytes.push_back(PREFIX_CHARS[i]);
			lim = room(cap_ply, MAX_PLY_DIGITS_DEF);
			n = (lim == 0 || $urandom_range(0, 11) == 0) ? lim + 1 : $urandom_range(1, lim);
			repeat (n) line_bytes.push_back(CH_0 + 8'($urandom_range(0, 9)));
			line_bytes.push_back(CH_SPACE);
			line_bytes.push_back(CH_A + 8'($urandom_range(0, 7)));
			line_bytes.push_back(CH_1 + 8'($urandom_range(0, 7)));
			line_bytes.push_back(CH_A + 8'($urandom_range(0, 7)));
			line_bytes.push_back(CH_1 + 8'($urandom_range(0, 7)));
			if ($urandom_range(0, 2) == 0)
				line_bytes.push_back(PROMO_CHARS[$urandom_range(0, 3)]);
			if ($urandom_range(0, 3) != 0) begin
				line_bytes.push_back(CH_SPACE);
				n = $urandom_range(0, 11);
				for (int k = 0; k < n; k++) begin
					if (k == 0 && $urandom_range(0, 4) == 0)
						line_bytes.push_back(CH_0 + 8'($urandom_range(0, 9)));
					else if ($urandom_range(0, 9) == 0)
						line_bytes.push_back(CH_SPACE);
					else
						line_bytes.push_back(8'($urandom_range(1, 255)));
				end
			end
			// Damage: overwrite one word or cut the line short
			if (kind == 1) begin
				pos = $urandom_range(0, line_bytes.size() - 1);
				if ($urandom_range(0, 1) == 0) begin
					line_bytes[pos] = 8'($urandom_range(1, 255));
				end else begin
					while (line_bytes.size() > pos)
						void'(line_bytes.pop_back());
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic typed_rpt_check(input move_report_t want);
		check_field("line_ok", 64'(want.line_ok), 64'(got_rpt.line_ok));
		check_field("ply_value", 64'(want.ply_value), 64'(got_rpt.ply_value));
		check_field("ply_digit_count", 64'(want.ply_digit_count), 64'(got_rpt.ply_digit_count));
		check_field("from_file", 64'(want.from_file), 64'(got_rpt.from_file));
		check_field("from_rank", 64'(want.from_rank), 64'(got_rpt.from_rank));
		check_field("to_file", 64'(want.to_file), 64'(got_rpt.to_file));
		check_field("to_rank", 64'(want.to_rank), 64'(got_rpt.to_rank));
		check_field("promotion", 64'(want.promotion), 64'(got_rpt.promotion));
		check_field("notation_bytes", want.notation_bytes, got_rpt.notation_bytes);
		check_field("notation_length", 64'(want.notation_length), 64'(got_rpt.notation_length));
	endtask

	// Receiver: switch between open, random and sparse ready patterns
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				rx_left = $urandom_range(10, 80);
			end
			rx_left--;
			case (rx_mode)
				RX_OPEN:   out_ready <= 1'b1;
				RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
				default:   out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Compare every taken report with the oldest queued one
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_rpt = '{line_ok, ply_value, ply_digit_count, from_file, from_rank,
				to_file, to_rank, promotion, notation_bytes, notation_length};
			if (pending_reports.size() == 0) begin
				$error("report taken with none pending");
				fail_count++;
			end else begin
				typed_rpt_check(pending_reports.pop_front());
			end
		end
	end

	// Watchdog: end the run when no word moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL move_message_line_parser_unit");
			$finish;
		end
	end

	initial begin
		int random_start;
		int random_lines;
		clear_line();

		// Directed table: typed reports where the answer is plain, the mirror elsewhere
		dir_rows.push_back(line_row("", 1'b1, '0));
		dir_rows.push_back(line_row("MOVE 1 e2e4", 1'b0, '0));
		dir_rows.push_back(line_row("MOVE 9999999 h8a1q", 1'b1,
			good_report(24'd9999999, 3'd7, 3'd7, 3'd7, 3'd0, 3'd0, PROMO_Q)));
		dir_rows.push_back(line_row("MOVE 0000000 a1h8n", 1'b1,
			good_report(24'd0, 3'd7, 3'd0, 3'd0, 3'd7, 3'd7, PROMO_N)));
		dir_rows.push_back(line_row("MOVE 12 e7e8r Nxf8=R", 1'b0, '0));
		dir_rows.push_back(line_row("MOVE 3 b7b8b abcdefghij", 1'b0, '0));
		dir_rows.push_back(line_row("MOVE 4 g1f3 1-0", 1'b0, '0));
		dir_rows.push_back(line_row("MOVE 5 c2c4 +  trailing text", 1'b0, '0));
		dir_rows.push_back(line_row("MOVE 6 d7d5 \377\377\377\377\377\377\377\377", 1'b0, '0));
		dir_rows.push_back(line_row("MOVE 1 e2e4 ", 1'b0, '0));
		dir_rows.push_back(line_row("MOVE 12345678 e2e4", 1'b1, '0));
		dir_rows.push_back(line_row("MOVE 1 e2e4qq", 1'b1, '0));
		dir_rows.push_back(line_row("MOVE 1 e2e", 1'b1, '0));
		dir_rows.push_back(line_row("MOVE 1", 1'b1, '0));
		dir_rows.push_back(line_row("move 1 e2e4", 1'b1, '0));
		dir_rows.push_back(line_row("MOVE  1 e2e4", 1'b1, '0));
		dir_rows.push_back(line_row("MOVE 1 i2e4", 1'b1, '0));
		dir_rows.push_back(line_row("MOVE 1 e9e4k", 1'b1, '0));
		dir_rows.push_back(line_row("\200\377MOVE", 1'b1, '0));
		dir_rows.push_back(caps_row(4'd0, 3'd0, 4'd0));
		dir_rows.push_back(line_row("MOVE 1 e2e4", 1'b1, '0));
		dir_rows.push_back(caps_row(4'd15, 3'd7, 4'd15));
		dir_rows.push_back(line_row("MOVE 9999999 a1a2b xyzwvuts12", 1'b0, '0));
		dir_rows.push_back(caps_row(PLY_CAP_RST, MOVE_CAP_RST, 4'd0));
		dir_rows.push_back(line_row("MOVE 7 d2d4 Qd4", 1'b0, '0));
		dir_rows.push_back(caps_row(4'd2, 3'd5, 4'd1));
		dir_rows.push_back(line_row("MOVE 5 a2a4 x", 1'b0, '0));
		dir_rows.push_back(line_row("MOVE 5 a2a4q", 1'b1, '0));
		dir_rows.push_back(caps_row(PLY_CAP_RST, MOVE_CAP_RST, NOTE_CAP_RST));

		// Hold reset, then release it on a clock edge
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CAPS) begin
				drain();
				program_caps(dir_rows[i].ply_cap, dir_rows[i].mv_cap, dir_rows[i].note_cap);
			end else begin
				typed_on  = dir_rows[i].typed;
				typed_rpt = dir_rows[i].rpt;
				for (int k = 0; k < dir_rows[i].text.len(); k++)
					send_char(dir_rows[i].text[k]);
				send_char(CH_NUL);
				typed_on = 1'b0;
			end
		end

		// Random lines; drain and pick new capacities every few lines
		random_start = words_sent;
		random_lines = 0;
		while (words_sent - random_start < RANDOM_WORDS || random_lines < RANDOM_LINES) begin
			if (random_lines % LINES_PER_PHASE == 0 && random_lines != 0) begin
				drain();
				program_caps(
					($urandom_range(0, 5) == 0) ?
						(($urandom_range(0, 1) == 0) ? 4'd0 : 4'd15) :
						4'($urandom_range(2, 8)),
					($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 4)) :
						3'($urandom_range(5, 7)),
					($urandom_range(0, 5) == 0) ?
						(($urandom_range(0, 1) == 0) ? 4'd0 : 4'd15) :
						4'($urandom_range(1, 9)));
			end
			compose_line();
			foreach (line_bytes[k])
				send_char(line_bytes[k]);
			send_char(CH_NUL);
			random_lines++;
		end

		drain();
		if (fail_count == 0)
			$display("PASS move_message_line_parser_unit");
		else
			$display("FAIL move_message_line_parser_unit");
		$finish;
	end

endmodule
